[rtl/rpu_pkg.sv]
// rpu_pkg: shared types, constants and helper functions for the pick ray unprojection block
// depends on nothing; imported by every rtl module of the block except rpu_delay
`default_nettype none

package rpu_pkg;

	typedef logic signed [63:0] wide_t;

	// largest magnitude of a wide intermediate
	localparam logic [63:0] MAG_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam wide_t WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;

	// quotient bits below the saturation point of a wide value
	localparam int QUO_BITS = 62;
	localparam int QMUL_LAT = 4;
	localparam int QDIV_LAT = QUO_BITS + 3;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_SCALE_X = 2'd2,
		REG_SCALE_Y = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [63:0] view_r0_ab;
		logic [63:0] view_r0_cd;
		logic [63:0] view_r1_ab;
		logic [63:0] view_r1_cd;
		logic [63:0] view_r2_ab;
		logic [63:0] view_r2_cd;
		logic [63:0] view_r3_ab;
		logic [63:0] view_r3_cd;
	} ray_in_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic               singular;
	} ray_out_t;

	function automatic wide_t sat_add(input wide_t a, input wide_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(WMAX))
			return WMAX;
		else if (s < -65'(WMAX))
			return -WMAX;
		else
			return s[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input wide_t v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic wide_t sx32(input logic [31:0] x);
		return 64'($signed(x));
	endfunction

	// k-th index of 0..3 that skips idx
	function automatic int excl(input int idx, input int k);
		return (k < idx) ? k : k + 1;
	endfunction

	// row pair of the 2x2 minors used by the cofactors of row r
	function automatic int rpair(input int r);
		case (r)
			0, 1:    return 0;
			2:       return 1;
			default: return 2;
		endcase
	endfunction

	function automatic int rp_lo(input int rp);
		case (rp)
			0:       return 2;
			default: return 1;
		endcase
	endfunction

	function automatic int rp_hi(input int rp);
		case (rp)
			2:       return 2;
			default: return 3;
		endcase
	endfunction

	function automatic int cp_lo(input int cp);
		case (cp)
			0, 1, 2: return 0;
			3, 4:    return 1;
			default: return 2;
		endcase
	endfunction

	function automatic int cp_hi(input int cp);
		case (cp)
			0:       return 1;
			1, 3:    return 2;
			default: return 3;
		endcase
	endfunction

	function automatic int cp_idx(input int a, input int b);
		case (a)
			0:       return b - 1;
			1:       return b + 1;
			default: return 5;
		endcase
	endfunction

endpackage

`default_nettype wire

[rtl/rpu_delay.sv]
// rpu_delay: enable-gated delay line that keeps side data aligned with the pipeline
// depends on nothing
`default_nettype none

module rpu_delay #(
	parameter int W = 64,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	generate
		if (D == 0) begin : g_none
			assign dout = din;
		end else begin : g_taps
			logic [W-1:0] tap_s [D];
			always_ff @(posedge clk) begin
				if (en) begin
					tap_s[0] <= din;
					for (int i = 1; i < D; i++)
						tap_s[i] <= tap_s[i-1];
				end
			end
			assign dout = tap_s[D-1];
		end
	endgenerate
endmodule

`default_nettype wire

[rtl/rpu_qmul.sv]
// rpu_qmul: pipelined fixed-point multiply, round half away from zero, saturate
// depends on rpu_pkg
`default_nettype none

module rpu_qmul #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  rpu_pkg::wide_t a,
	input  rpu_pkg::wide_t b,
	output rpu_pkg::wide_t p
);
	import rpu_pkg::*;

	localparam logic [127:0] HALF = 128'(1) << (FRAC_BITS - 1);

	logic [63:0]  ma_s1, mb_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  pp00_s2, pp01_s2, pp10_s2, pp11_s2;
	logic [127:0] sum_s3;
	logic [127:0] shf;
	logic [63:0]  mag;
	wide_t        p_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= a[63] ? 64'(-a) : 64'(a);
			mb_s1   <= b[63] ? 64'(-b) : 64'(b);
			neg_s1  <= a[63] ^ b[63];
			pp00_s2 <= ma_s1[31:0] * mb_s1[31:0];
			pp01_s2 <= ma_s1[31:0] * mb_s1[63:32];
			pp10_s2 <= ma_s1[63:32] * mb_s1[31:0];
			pp11_s2 <= ma_s1[63:32] * mb_s1[63:32];
			neg_s2  <= neg_s1;
			sum_s3  <= 128'(pp00_s2) + (128'(pp01_s2) << 32) + (128'(pp10_s2) << 32)
				+ (128'(pp11_s2) << 64) + HALF;
			neg_s3  <= neg_s2;
			p_s4    <= neg_s3 ? -$signed(mag) : $signed(mag);
		end
	end

	assign shf = sum_s3 >> FRAC_BITS;
	assign mag = (|shf[127:62]) ? MAG_MAX : shf[63:0];
	assign p   = p_s4;
endmodule

`default_nettype wire

[rtl/rpu_qdiv.sv]
// rpu_qdiv: pipelined restoring divider, round(n * 2^FRAC_BITS / d), saturate
// depends on rpu_pkg; one quotient bit per stage
`default_nettype none

module rpu_qdiv #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  rpu_pkg::wide_t n,
	input  rpu_pkg::wide_t d,
	output rpu_pkg::wide_t q
);
	import rpu_pkg::*;

	logic [63:0]          un_s1, ud_s1;
	logic                 neg_s1;
	logic [127:0]         nfull;
	logic [63:0]          rem_s [QUO_BITS+1];
	logic [QUO_BITS-1:0]  low_s [QUO_BITS];
	logic [QUO_BITS-1:0]  quo_s [QUO_BITS+1];
	logic [63:0]          ud_s  [QUO_BITS+1];
	logic                 neg_s [QUO_BITS+1];
	logic                 ovf_s [QUO_BITS+1];
	logic                 rnd;
	logic [63:0]          magq, mag;
	wide_t                res_s;

	assign nfull = 128'(un_s1) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			un_s1    <= n[63] ? 64'(-n) : 64'(n);
			ud_s1    <= d[63] ? 64'(-d) : 64'(d);
			neg_s1   <= n[63] ^ d[63];
			// quotient at or above 2^62 saturates whatever the rounding
			ovf_s[0] <= nfull >= (128'(ud_s1) << QUO_BITS);
			rem_s[0] <= nfull[QUO_BITS+63:QUO_BITS];
			low_s[0] <= nfull[QUO_BITS-1:0];
			quo_s[0] <= '0;
			ud_s[0]  <= ud_s1;
			neg_s[0] <= neg_s1;
		end
	end

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
		logic [63:0] trial;
		logic        ge;
		assign trial = {rem_s[k][62:0], low_s[k][QUO_BITS-1]};
		assign ge    = trial >= ud_s[k];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? trial - ud_s[k] : trial;
				quo_s[k+1] <= {quo_s[k][QUO_BITS-2:0], ge};
				ud_s[k+1]  <= ud_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
		if (k + 1 < QUO_BITS) begin : g_low
			always_ff @(posedge clk) begin
				if (en)
					low_s[k+1] <= low_s[k] << 1;
			end
		end
	end

	assign rnd  = {rem_s[QUO_BITS][62:0], 1'b0} >= ud_s[QUO_BITS];
	assign magq = {2'b00, quo_s[QUO_BITS]} + 64'(rnd);
	assign mag  = (ovf_s[QUO_BITS] || magq > MAG_MAX) ? MAG_MAX : magq;

	always_ff @(posedge clk) begin
		if (en)
			res_s <= neg_s[QUO_BITS] ? -$signed(mag) : $signed(mag);
	end

	assign q = res_s;
endmodule

`default_nettype wire

[rtl/rpu_obuf.sv]
// rpu_obuf: two-entry output buffer, head register plus skid entry
// depends on rpu_pkg for the result type
`default_nettype none

module rpu_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rpu_pkg::ray_out_t din,
	output logic              out_valid,
	input  logic              out_ready,
	output rpu_pkg::ray_out_t dout,
	output logic              full
);
	import rpu_pkg::*;

	logic     head_v_q, skid_v_q;
	ray_out_t head_q, skid_q;
	logic     move;

	// head is free to load this cycle
	assign move = !head_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (move) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			head_q <= skid_v_q ? skid_q : din;
			if (skid_v_q && push)
				skid_q <= din;
		end else if (push) begin
			skid_q <= din;
		end
	end

	assign out_valid = head_v_q;
	assign dout      = head_q;
	assign full      = skid_v_q;
endmodule

`default_nettype wire

[rtl/screen_pick_ray_unproject_top.sv]
// screen_pick_ray_unproject_top: cursor pixel plus 4x4 view matrix in, world pick ray out
// depends on rpu_pkg, rpu_qmul, rpu_qdiv, rpu_delay, rpu_obuf
// the longest path runs through the two chained 65-stage dividers of the ndc path
//   followed by the 65-stage direction divider
// throughput: one transaction per cycle unless the output buffer is full; all units fully pipelined
// reset: clears the valid pipeline, the output buffer and the config registers to defaults
`default_nettype none

module screen_pick_ray_unproject_top #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_MAX = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pick_valid,
	output logic              pick_ready,
	input  rpu_pkg::ray_in_t  pick,
	output logic              ray_valid,
	input  logic              ray_ready,
	output rpu_pkg::ray_out_t ray,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import rpu_pkg::*;

	// schedule, in cycles after the input stage s1
	localparam int LM = QMUL_LAT;
	localparam int LD = QDIV_LAT;
	localparam int TMN = LM + 1;          // 2x2 minors ready
	localparam int TC = 2 * LM + 3;       // cofactors ready
	localparam int TD = TC + LM + 3;      // determinant ready
	localparam int TV = 2 * LD;           // view direction ready
	localparam int TN = TV + LM + 2;      // direction numerators ready
	localparam int TF = TN + LD;          // all quotients ready

	// ---------------------------------------------------------------- config
	logic [12:0] width_q, height_q;
	logic [30:0] scale_x_q, scale_y_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 13'd1024;
			height_q  <= 13'd768;
			scale_x_q <= 31'd65536;
			scale_y_q <= 31'd65536;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:   width_q   <= pwdata[12:0];
				REG_HEIGHT:  height_q  <= pwdata[12:0];
				REG_SCALE_X: scale_x_q <= pwdata[30:0];
				REG_SCALE_Y: scale_y_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:   prdata = {19'b0, width_q};
			REG_HEIGHT:  prdata = {19'b0, height_q};
			REG_SCALE_X: prdata = {1'b0, scale_x_q};
			REG_SCALE_Y: prdata = {1'b0, scale_y_q};
			default:     prdata = '0;
		endcase
	end

	// zero registers act as one
	logic [12:0] w_eff, h_eff;
	logic [30:0] sx_eff, sy_eff;
	assign w_eff  = (width_q == '0) ? 13'd1 : width_q;
	assign h_eff  = (height_q == '0) ? 13'd1 : height_q;
	assign sx_eff = (scale_x_q == '0) ? 31'd1 : scale_x_q;
	assign sy_eff = (scale_y_q == '0) ? 31'd1 : scale_y_q;

	// ---------------------------------------------------------------- flow control
	// the whole pipeline advances unless the skid entry of the output buffer is taken
	logic        en, buf_full, push;
	logic [TF:0] vld_q;
	ray_out_t    res_c;

	assign en         = !buf_full;
	assign pick_ready = en;
	assign push       = en && vld_q[TF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TF-1:0], pick_valid};
	end

	// ---------------------------------------------------------------- input stage
	logic [63:0] row_ab [4];
	logic [63:0] row_cd [4];
	logic [11:0] px_cl, py_cl;
	wide_t       nx_c, ny_c;
	logic [31:0] elem_s1 [4][4];
	wide_t       nx_s1, ny_s1;

	assign row_ab[0] = pick.view_r0_ab;
	assign row_cd[0] = pick.view_r0_cd;
	assign row_ab[1] = pick.view_r1_ab;
	assign row_cd[1] = pick.view_r1_cd;
	assign row_ab[2] = pick.view_r2_ab;
	assign row_cd[2] = pick.view_r2_cd;
	assign row_ab[3] = pick.view_r3_ab;
	assign row_cd[3] = pick.view_r3_cd;

	// cursor beyond the coordinate range is pinned to the last pixel
	assign px_cl = (32'(pick.pos_x) >= COORD_MAX) ? 12'(COORD_MAX - 1) : pick.pos_x;
	assign py_cl = (32'(pick.pos_y) >= COORD_MAX) ? 12'(COORD_MAX - 1) : pick.pos_y;

	// ndc numerators: 2*px - w and h - 2*py
	assign nx_c = $signed({51'b0, px_cl, 1'b0}) - $signed({51'b0, w_eff});
	assign ny_c = $signed({51'b0, h_eff}) - $signed({51'b0, py_cl, 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				elem_s1[r][0] <= row_ab[r][31:0];
				elem_s1[r][1] <= row_ab[r][63:32];
				elem_s1[r][2] <= row_cd[r][31:0];
				elem_s1[r][3] <= row_cd[r][63:32];
			end
			nx_s1 <= nx_c;
			ny_s1 <= ny_c;
		end
	end

	// ---------------------------------------------------------------- ndc and view direction
	wide_t ndc_x, ndc_y, vx, vy;

	rpu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_ndc_x (
		.clk(clk), .en(en), .n(nx_s1), .d($signed({51'b0, w_eff})), .q(ndc_x));
	rpu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_ndc_y (
		.clk(clk), .en(en), .n(ny_s1), .d($signed({51'b0, h_eff})), .q(ndc_y));
	rpu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_view_x (
		.clk(clk), .en(en), .n(ndc_x), .d($signed({33'b0, sx_eff})), .q(vx));
	rpu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_view_y (
		.clk(clk), .en(en), .n(ndc_y), .d($signed({33'b0, sy_eff})), .q(vy));

	// ---------------------------------------------------------------- matrix elements, delayed
	// rows 0 and 1 feed the cofactor expansion; row 0 also feeds the determinant
	logic [31:0] elem_mn [2][4];
	logic [31:0] elem_tc [4];

	for (genvar r = 0; r < 2; r++) begin : g_erow
		for (genvar c = 0; c < 4; c++) begin : g_ecol
			rpu_delay #(.W(32), .D(TMN)) u_dly (
				.clk(clk), .en(en), .din(elem_s1[r][c]), .dout(elem_mn[r][c]));
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_e0
		rpu_delay #(.W(32), .D(TC - TMN)) u_dly (
			.clk(clk), .en(en), .din(elem_mn[0][c]), .dout(elem_tc[c]));
	end

	// ---------------------------------------------------------------- 2x2 minors
	// row pairs (2,3), (1,3), (1,2) against all six column pairs
	wide_t minor_s6 [3][6];

	for (genvar rp = 0; rp < 3; rp++) begin : g_mrow
		for (genvar cp = 0; cp < 6; cp++) begin : g_mcol
			localparam int RA = rp_lo(rp);
			localparam int RB = rp_hi(rp);
			localparam int CA = cp_lo(cp);
			localparam int CB = cp_hi(cp);
			wide_t pa, pb;
			rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pa (.clk(clk), .en(en),
				.a(sx32(elem_s1[RA][CA])), .b(sx32(elem_s1[RB][CB])), .p(pa));
			rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pb (.clk(clk), .en(en),
				.a(sx32(elem_s1[RA][CB])), .b(sx32(elem_s1[RB][CA])), .p(pb));
			always_ff @(posedge clk) begin
				if (en)
					minor_s6[rp][cp] <= sat_add(pa, -pb);
			end
		end
	end

	// ---------------------------------------------------------------- cofactors
	// expansion along the first remaining row, signed by (r + c) parity;
	// bottom-row cofactors other than the w term are never needed
	wide_t cof_s12 [4][4];

	for (genvar r = 0; r < 4; r++) begin : g_crow
		for (genvar c = 0; c < 4; c++) begin : g_ccol
			if (r < 3 || c == 3) begin : g_used
				localparam int RP  = rpair(r);
				localparam int RS0 = excl(r, 0);
				localparam int CS0 = excl(c, 0);
				localparam int CS1 = excl(c, 1);
				localparam int CS2 = excl(c, 2);
				localparam bit ODD = ((r + c) % 2) == 1;
				wide_t pa, pb, pc, dsum;
				wide_t d1_s11, pc_s11;
				rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pa (.clk(clk), .en(en),
					.a(sx32(elem_mn[RS0][CS0])), .b(minor_s6[RP][cp_idx(CS1, CS2)]), .p(pa));
				rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pb (.clk(clk), .en(en),
					.a(sx32(elem_mn[RS0][CS1])), .b(minor_s6[RP][cp_idx(CS0, CS2)]), .p(pb));
				rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pc (.clk(clk), .en(en),
					.a(sx32(elem_mn[RS0][CS2])), .b(minor_s6[RP][cp_idx(CS0, CS1)]), .p(pc));
				assign dsum = sat_add(d1_s11, pc_s11);
				always_ff @(posedge clk) begin
					if (en) begin
						d1_s11        <= sat_add(pa, -pb);
						pc_s11        <= pc;
						cof_s12[r][c] <= ODD ? -dsum : dsum;
					end
				end
			end else begin : g_unused
				always_ff @(posedge clk) begin
					if (en)
						cof_s12[r][c] <= '0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- determinant
	// summed in column order, one saturating add per stage
	wide_t dp [4];
	wide_t det_a_s17, dp2_s17, dp3_s17, det_b_s18, dp3_s18, det_s19;

	for (genvar c = 0; c < 4; c++) begin : g_det
		rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_dp (.clk(clk), .en(en),
			.a(sx32(elem_tc[c])), .b(cof_s12[0][c]), .p(dp[c]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_a_s17 <= sat_add(dp[0], dp[1]);
			dp2_s17   <= dp[2];
			dp3_s17   <= dp[3];
			det_b_s18 <= sat_add(det_a_s17, dp2_s17);
			dp3_s18   <= dp3_s17;
			det_s19   <= sat_add(det_b_s18, dp3_s18);
		end
	end

	// ---------------------------------------------------------------- origin
	// translation row over its w term; w zero gives a signed saturated value, or zero for a zero numerator
	wide_t w_div;
	wide_t org_q [3];
	logic [2:0] org_flag [3];

	assign w_div = (cof_s12[3][3] == '0) ? 64'sd1 : cof_s12[3][3];

	for (genvar j = 0; j < 3; j++) begin : g_org
		wide_t oq;
		rpu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .en(en),
			.n(cof_s12[j][3]), .d(w_div), .q(oq));
		rpu_delay #(.W(64), .D(TF - TC - LD)) u_dq (.clk(clk), .en(en),
			.din(oq), .dout(org_q[j]));
		rpu_delay #(.W(3), .D(TF - TC)) u_df (.clk(clk), .en(en),
			.din({cof_s12[3][3] == '0, cof_s12[j][3] > 0, cof_s12[j][3] < 0}),
			.dout(org_flag[j]));
	end

	// ---------------------------------------------------------------- direction
	wide_t det_tn, det_div;
	logic  det_zero;
	wide_t dir_q [3];

	rpu_delay #(.W(64), .D(TN - TD)) u_det_dly (.clk(clk), .en(en),
		.din(det_s19), .dout(det_tn));
	assign det_div = (det_tn == '0) ? 64'sd1 : det_tn;
	rpu_delay #(.W(1), .D(LD)) u_detz_dly (.clk(clk), .en(en),
		.din(det_tn == '0), .dout(det_zero));

	for (genvar j = 0; j < 3; j++) begin : g_dir
		wide_t c0, c1, c2, pa, pb;
		wide_t dsum_s136, dn_s137;
		rpu_delay #(.W(64), .D(TV - TC)) u_c0 (.clk(clk), .en(en),
			.din(cof_s12[j][0]), .dout(c0));
		rpu_delay #(.W(64), .D(TV - TC)) u_c1 (.clk(clk), .en(en),
			.din(cof_s12[j][1]), .dout(c1));
		rpu_delay #(.W(64), .D(TV + LM + 1 - TC)) u_c2 (.clk(clk), .en(en),
			.din(cof_s12[j][2]), .dout(c2));
		rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pa (.clk(clk), .en(en), .a(vx), .b(c0), .p(pa));
		rpu_qmul #(.FRAC_BITS(FRAC_BITS)) u_pb (.clk(clk), .en(en), .a(vy), .b(c1), .p(pb));
		always_ff @(posedge clk) begin
			if (en) begin
				dsum_s136 <= sat_add(pa, pb);
				dn_s137   <= sat_add(dsum_s136, c2);
			end
		end
		rpu_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .en(en),
			.n(dn_s137), .d(det_div), .q(dir_q[j]));
	end

	// ---------------------------------------------------------------- result
	wide_t org_sel [3];

	for (genvar j = 0; j < 3; j++) begin : g_osel
		assign org_sel[j] = !org_flag[j][2] ? org_q[j] :
			org_flag[j][1] ? WMAX : org_flag[j][0] ? -WMAX : 64'sd0;
	end

	// singular matrix zeroes every origin and direction field
	assign res_c.origin_x = det_zero ? 32'sd0 : clamp32(org_sel[0]);
	assign res_c.origin_y = det_zero ? 32'sd0 : clamp32(org_sel[1]);
	assign res_c.origin_z = det_zero ? 32'sd0 : clamp32(org_sel[2]);
	assign res_c.dir_x    = det_zero ? 32'sd0 : clamp32(dir_q[0]);
	assign res_c.dir_y    = det_zero ? 32'sd0 : clamp32(dir_q[1]);
	assign res_c.dir_z    = det_zero ? 32'sd0 : clamp32(dir_q[2]);
	assign res_c.singular = det_zero;

	rpu_obuf u_obuf (
		.clk(clk), .arst_n(arst_n), .push(push), .din(res_c),
		.out_valid(ray_valid), .out_ready(ray_ready), .dout(ray), .full(buf_full));

	// ---------------------------------------------------------------- checks
	// a singular transaction carries zero ray fields
	assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && ray.singular |-> ray.origin_x == 0 && ray.origin_y == 0 &&
		ray.origin_z == 0 && ray.dir_x == 0 && ray.dir_y == 0 && ray.dir_z == 0)
		else $error("singular ray with nonzero fields");

	// a stalled pipeline holds its valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		!pick_ready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	// input stalls only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		!pick_ready |-> ray_valid)
		else $error("input stalled with no pending result");

endmodule

`default_nettype wire

[tb/ray_pick_checker.sv]
// ray_pick_checker: watches the pick, ray and register ports of the unprojection block,
// predicts each world ray in fixed point and compares it with what the block returns
// depends on rpu_pkg (ray_in_t, ray_out_t, reg_idx_t, wide_t)
`default_nettype none

module ray_pick_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pick_valid,
	input  logic              pick_ready,
	input  rpu_pkg::ray_in_t  pick,
	input  logic              ray_valid,
	input  logic              ray_ready,
	input  rpu_pkg::ray_out_t ray,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                errors,
	output int                pending
);
	import rpu_pkg::*;

	localparam int FB = 16;
	localparam int CMAX = 4096;
	localparam logic [63:0] LIM = 64'h3FFF_FFFF_FFFF_FFFF;

	typedef wide_t mat_t [4][4];

	logic [12:0] width_q, height_q;
	logic [30:0] scale_x_q, scale_y_q;
	ray_out_t    rays_due[$];

	function automatic logic [63:0] absval(input wide_t v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic wide_t with_sign(input logic neg, input logic [127:0] m);
		wide_t r;
		r = (m > 128'(LIM)) ? wide_t'(LIM) : wide_t'(m[63:0]);
		return neg ? -r : r;
	endfunction

	function automatic wide_t clip_add(input wide_t a, input wide_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(wide_t'(LIM)))
			return wide_t'(LIM);
		if (s < -65'(wide_t'(LIM)))
			return -wide_t'(LIM);
		return s[63:0];
	endfunction

	function automatic wide_t fx_mul(input wide_t a, input wide_t b);
		logic [127:0] p;
		p = {64'd0, absval(a)} * {64'd0, absval(b)};
		p = (p + (128'd1 << (FB - 1))) >> FB;
		return with_sign((a < 0) != (b < 0), p);
	endfunction

	function automatic wide_t fx_div(input wide_t n, input wide_t d);
		logic [127:0] num, den, q, r;
		num = {64'd0, absval(n)} << FB;
		den = {64'd0, absval(d)};
		q = num / den;
		r = num % den;
		if ((r << 1) >= den)
			q = q + 1;
		return with_sign((n < 0) != (d < 0), q);
	endfunction

	function automatic wide_t minor3(input mat_t m, input int r, input int c);
		int rs[3], cs[3];
		int k, i;
		wide_t a, b, e, d;
		k = 0;
		for (i = 0; i < 4; i++)
			if (i != r) begin
				rs[k] = i;
				k++;
			end
		k = 0;
		for (i = 0; i < 4; i++)
			if (i != c) begin
				cs[k] = i;
				k++;
			end
		a = clip_add(fx_mul(m[rs[1]][cs[1]], m[rs[2]][cs[2]]),
			-fx_mul(m[rs[1]][cs[2]], m[rs[2]][cs[1]]));
		b = clip_add(fx_mul(m[rs[1]][cs[0]], m[rs[2]][cs[2]]),
			-fx_mul(m[rs[1]][cs[2]], m[rs[2]][cs[0]]));
		e = clip_add(fx_mul(m[rs[1]][cs[0]], m[rs[2]][cs[1]]),
			-fx_mul(m[rs[1]][cs[1]], m[rs[2]][cs[0]]));
		d = clip_add(clip_add(fx_mul(m[rs[0]][cs[0]], a), -fx_mul(m[rs[0]][cs[1]], b)),
			fx_mul(m[rs[0]][cs[2]], e));
		return ((r + c) % 2 == 1) ? -d : d;
	endfunction

	function automatic ray_out_t unproject(input ray_in_t p);
		logic [63:0] rows [8];
		mat_t     m, cof;
		wide_t    px, py, w, h, sx, sy, vx, vy, det, o, dn;
		wide_t    res [6];
		ray_out_t y;
		int       r, c;
		rows = '{p.view_r0_ab, p.view_r0_cd, p.view_r1_ab, p.view_r1_cd,
			p.view_r2_ab, p.view_r2_cd, p.view_r3_ab, p.view_r3_cd};
		for (r = 0; r < 4; r++) begin
			m[r][0] = sx32(rows[2*r][31:0]);
			m[r][1] = sx32(rows[2*r][63:32]);
			m[r][2] = sx32(rows[2*r+1][31:0]);
			m[r][3] = sx32(rows[2*r+1][63:32]);
		end
		px = (p.pos_x >= CMAX) ? 64'(CMAX - 1) : 64'(p.pos_x);
		py = (p.pos_y >= CMAX) ? 64'(CMAX - 1) : 64'(p.pos_y);
		w  = (width_q == 0) ? 64'sd1 : 64'(width_q);
		h  = (height_q == 0) ? 64'sd1 : 64'(height_q);
		sx = (scale_x_q == 0) ? 64'sd1 : 64'(scale_x_q);
		sy = (scale_y_q == 0) ? 64'sd1 : 64'(scale_y_q);
		vx = fx_div(fx_div(2 * px - w, w), sx);
		vy = fx_div(fx_div(h - 2 * py, h), sy);
		for (r = 0; r < 4; r++)
			for (c = 0; c < 4; c++)
				cof[r][c] = minor3(m, r, c);
		det = 0;
		for (c = 0; c < 4; c++)
			det = clip_add(det, fx_mul(m[0][c], cof[0][c]));
		y = '0;
		if (det == 0) begin
			y.singular = 1'b1;
			return y;
		end
		for (r = 0; r < 3; r++) begin
			// w of zero: origin goes to the rail that matches its numerator, or to zero for a zero numerator
			if (cof[3][3] == 0)
				o = (cof[r][3] > 0) ? wide_t'(LIM) : ((cof[r][3] < 0) ? -wide_t'(LIM) : 0);
			else
				o = fx_div(cof[r][3], cof[3][3]);
			res[r] = o;
			dn = clip_add(clip_add(fx_mul(vx, cof[r][0]), fx_mul(vy, cof[r][1])), cof[r][2]);
			res[3 + r] = fx_div(dn, det);
		end
		y.origin_x = clamp32(res[0]);
		y.origin_y = clamp32(res[1]);
		y.origin_z = clamp32(res[2]);
		y.dir_x    = clamp32(res[3]);
		y.dir_y    = clamp32(res[4]);
		y.dir_z    = clamp32(res[5]);
		return y;
	endfunction

	assign pending = rays_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 13'd1024;
			height_q  <= 13'd768;
			scale_x_q <= 31'd65536;
			scale_y_q <= 31'd65536;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:   width_q   <= pwdata[12:0];
				REG_HEIGHT:  height_q  <= pwdata[12:0];
				REG_SCALE_X: scale_x_q <= pwdata[30:0];
				REG_SCALE_Y: scale_y_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	initial errors = 0;

	always @(posedge clk) begin
		ray_out_t want;
		if (arst_n && pick_valid && pick_ready)
			rays_due.push_back(unproject(pick));
		if (arst_n && ray_valid && ray_ready) begin
			if (rays_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected ray transaction: %p", ray);
			end else begin
				want = rays_due.pop_front();
				if (ray.origin_x !== want.origin_x || ray.origin_y !== want.origin_y ||
					ray.origin_z !== want.origin_z || ray.dir_x !== want.dir_x ||
					ray.dir_y !== want.dir_y || ray.dir_z !== want.dir_z ||
					ray.singular !== want.singular) begin
					errors++;
					if (errors <= 10)
						$display("ray mismatch: expected %p actual %p", want, ray);
				end
			end
		end
	end

endmodule

`default_nettype wire

[tb/screen_pick_ray_unproject_top_test.sv]
// screen_pick_ray_unproject_top_test: stimulus and verdict for the pick ray unprojection block
// depends on rpu_pkg, screen_pick_ray_unproject_top and ray_pick_checker
`default_nettype none

module screen_pick_ray_unproject_top_test;
	import rpu_pkg::*;

	localparam int DRAIN = 260;
	localparam int ONE = 65536;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pick_valid = 1'b0;
	logic        pick_ready;
	ray_in_t     pick = '0;
	logic        ray_valid;
	logic        ray_ready = 1'b0;
	ray_out_t    ray;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	bit          idling = 1'b1;
	int          stall_left = 0;

	screen_pick_ray_unproject_top DUT (
		.clk(clk), .arst_n(arst_n),
		.pick_valid(pick_valid), .pick_ready(pick_ready), .pick(pick),
		.ray_valid(ray_valid), .ray_ready(ray_ready), .ray(ray),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ray_pick_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.pick_valid(pick_valid), .pick_ready(pick_ready), .pick(pick),
		.ray_valid(ray_valid), .ray_ready(ray_ready), .ray(ray),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	always #4 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver stalls come in random bursts that start only while idling is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			ray_ready = 1'b0;
			stall_left--;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			ray_ready = 1'b0;
			stall_left = $urandom_range(1, 9) - 1;
		end else begin
			ray_ready = 1'b1;
		end
	end

	// apb write: setup cycle then access cycle
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic set_view(input logic [11:0] x, input logic [11:0] y,
		input logic [31:0] e [16]);
		pick.pos_x = x;
		pick.pos_y = y;
		pick.view_r0_ab = {e[1], e[0]};
		pick.view_r0_cd = {e[3], e[2]};
		pick.view_r1_ab = {e[5], e[4]};
		pick.view_r1_cd = {e[7], e[6]};
		pick.view_r2_ab = {e[9], e[8]};
		pick.view_r2_cd = {e[11], e[10]};
		pick.view_r3_ab = {e[13], e[12]};
		pick.view_r3_cd = {e[15], e[14]};
	endtask

	// one pick transaction, called at a falling edge with the payload already set
	task automatic send_pick();
		int gap;
		if (idling && $urandom_range(0, 7) == 0) begin
			pick_valid = 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(negedge clk);
		end
		pick_valid = 1'b1;
		@(posedge clk);
		while (!pick_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] small_fx(input int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// mostly camera-like matrices, plus raw bits, singular, zero-w and power-of-two diagonal ones
	task automatic random_pick();
		logic [31:0] e [16];
		int kind, i;
		kind = $urandom_range(0, 9);
		for (i = 0; i < 16; i++)
			e[i] = small_fx(3 * ONE);
		if (kind < 6) begin
			e[3] = 0;
			e[7] = 0;
			e[11] = 0;
			e[15] = ONE;
			e[12] = small_fx(200 * ONE);
			e[13] = small_fx(200 * ONE);
			e[14] = small_fx(200 * ONE);
		end else if (kind == 6) begin
			for (i = 0; i < 16; i++)
				e[i] = $urandom();
		end else if (kind == 7) begin
			// two equal rows
			for (i = 0; i < 4; i++)
				e[8 + i] = e[4 + i];
		end else if (kind == 8) begin
			// upper 3x3 made singular so the w cofactor vanishes
			for (i = 0; i < 3; i++)
				e[8 + i] = e[4 + i];
		end else begin
			for (i = 0; i < 16; i++)
				e[i] = (i % 5 == 0) ? ONE << $urandom_range(0, 4) : $urandom_range(0, 1) << 16;
		end
		set_view(12'($urandom()), 12'($urandom()), e);
		send_pick();
	endtask

	task automatic directed_picks();
		logic [31:0] e [16];
		logic [11:0] xs [4];
		int i, k;
		xs = '{12'd0, 12'd4095, 12'd512, 12'd1023};
		for (k = 0; k < 4; k++) begin
			for (i = 0; i < 16; i++)
				e[i] = (i % 5 == 0) ? ONE : 0;
			if (k >= 2)
				e[12] = 32'(10 * ONE);
			set_view(xs[k], xs[3 - k], e);
			send_pick();
		end
		// all zero matrix is singular
		for (i = 0; i < 16; i++)
			e[i] = 0;
		set_view(12'd100, 12'd200, e);
		send_pick();
		// permutation with a zero w cofactor
		e[3] = ONE;
		e[4] = ONE;
		e[9] = ONE;
		e[14] = ONE;
		set_view(12'd4095, 12'd0, e);
		send_pick();
		e[3] = -ONE;
		e[12] = 32'(5 * ONE);
		e[13] = -32'(7 * ONE);
		set_view(12'd0, 12'd4095, e);
		send_pick();
		// element extremes
		for (k = 0; k < 4; k++) begin
			for (i = 0; i < 16; i++)
				e[i] = (i % 5 == 0) ? ((k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF)
					: ((k >= 2) ? 32'h7FFF_FFFF : 0);
			set_view(12'hFFF, 12'hFFF, e);
			send_pick();
		end
		for (k = 0; k < 4; k++) begin
			for (i = 0; i < 16; i++)
				e[i] = (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0001;
			e[(k * 5) % 16] = 32'(ONE);
			set_view(12'hAAA, 12'h555, e);
			send_pick();
		end
	endtask

	task automatic run_phase(input logic [31:0] wd, input logic [31:0] ht,
		input logic [31:0] scx, input logic [31:0] scy, input int count);
		int n;
		wait_idle();
		write_reg(REG_WIDTH, wd);
		write_reg(REG_HEIGHT, ht);
		write_reg(REG_SCALE_X, scx);
		write_reg(REG_SCALE_Y, scy);
		for (n = 0; n < count; n++) begin
			random_pick();
			// in the 1920-wide phase, one mid-phase hold-off until every ray is back
			if (n == count / 2 && wd == 32'd1920) begin
				pick_valid = 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
		end
		pick_valid = 1'b0;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults first
		directed_picks();
		repeat (100) random_pick();
		pick_valid = 1'b0;

		run_phase(32'd0, 32'd0, 32'd0, 32'd0, 100);
		run_phase(32'd4096, 32'd4096, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 100);
		run_phase(32'd8191, 32'd1, 32'd1, 32'd65536, 100);
		run_phase(32'd1920, 32'd1080, 32'd98304, 32'd131072, 150);
		// last stretch runs without idling on either side
		idling = 1'b0;
		run_phase(32'd1, 32'd4095, 32'd43690, 32'd21845, 130);

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
